// ===== rtl/rc_ibus_frame_decoder_unit_defines.svh =====
// Assertion macros shared by the frame decoder RTL.
// No dependencies; included by the controller and the datapath.
`ifndef RC_IBUS_FRAME_DECODER_UNIT_DEFINES_SVH
`define RC_IBUS_FRAME_DECODER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RCIBUS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rcibus: same-cycle check failed");
`define RCIBUS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("rcibus: next-cycle check failed");
`else
`define RCIBUS_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define RCIBUS_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== rtl/rcibus_pkg.sv =====
// Shared types and constants for the radio-control frame decoder.
// No dependencies; used by rcibus_ctrl, rcibus_datapath and the top level.
package rcibus_pkg;

  localparam int CHANNELS_DEF = 14;
  localparam int FRAME_LEN    = 32;
  localparam int POS_W        = 5;
  localparam int IDX_W        = 4;
  localparam int VAL_W        = 16;
  localparam int LIMIT_W      = 8;

  localparam logic [POS_W-1:0]   SUM_LAST_POS = 5'd29;
  localparam logic [POS_W-1:0]   CSUM_LO_POS  = 5'd30;
  localparam logic [POS_W-1:0]   CSUM_HI_POS  = 5'd31;
  localparam logic [POS_W-1:0]   HDR0_POS     = 5'd0;
  localparam logic [POS_W-1:0]   HDR1_POS     = 5'd1;
  localparam logic [7:0]         HDR0_BYTE    = 8'h20;
  localparam logic [7:0]         HDR1_BYTE    = 8'h40;
  localparam logic [VAL_W-1:0]   SUM_INIT     = 16'hFFFF;
  localparam logic [VAL_W-1:0]   DEFAULT_MID  = 16'd1500;
  localparam logic [IDX_W-1:0]   MID_CH_A     = 4'd1;
  localparam logic [IDX_W-1:0]   MID_CH_B     = 4'd3;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 8'd10;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_CHAN     = 2'd0,
    ST_BAD_HDR  = 2'd1,
    ST_BAD_SUM  = 2'd2,
    ST_FAILSAFE = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    byte_wr;    // accepted byte transaction
    logic    tick;       // accepted failsafe tick
    logic    start;      // load result status, clear channel counter
    status_t start_st;
    logic    fetch;      // read the channel word from the frame RAM
    logic    next_chan;  // advance to the next channel
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic frame_end;   // incoming byte is the 32nd of its frame
    logic hdr_ok;
    logic sum_ok;
    logic fs_expire;   // incoming tick reaches the limit
    logic chan_mode;   // current run reads channels from the frame RAM
    logic last;        // current result closes the run
  } dp_stat_t;

endpackage

// ===== rtl/rc_ibus_frame_decoder_unit.sv =====
// Channel      Ports                         Payload (low bit first)
// in           in_tvalid/in_tready           tdata: rx_byte; tuser: req_type
// out          out_tvalid/out_tready         tdata: channel_index, channel_value;
//                                            tuser: status; tlast: last
// cfg          cfg_we/cfg_wdata              failsafe_limit
//
// A byte or tick that gives no result leaves the unit idle. A good frame end
// starts a run in which each channel takes a frame-RAM read (S_FETCH) and then
// an output (S_EMIT). A failsafe run skips the reads; an error gives one result.
// Input is taken only when no run is pending; out_tready low holds the result.
// rst_n is synchronous, active low; the frame RAM is not cleared.
// Top level of the frame decoder; depends on rcibus_pkg, rcibus_ctrl, rcibus_datapath.

module rc_ibus_frame_decoder_unit #(
  parameter int CHANNELS = rcibus_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] channel_index, [19:4] channel_value, zero pad
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  rcibus_pkg::dp_cmd_t             cmd;
  rcibus_pkg::dp_stat_t            stat;
  logic [1:0]                      res_status;
  logic [rcibus_pkg::IDX_W-1:0]    res_index;
  logic [rcibus_pkg::VAL_W-1:0]    res_value;

  rcibus_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_req     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rcibus_datapath #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .rx_byte    (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .res_status (res_status),
    .res_index  (res_index),
    .res_value  (res_value)
  );

  assign out_tdata = {4'h0, res_value, res_index};
  assign out_tuser = res_status;
  assign out_tlast = stat.last;

endmodule

// ===== rtl/rcibus_ctrl.sv =====
// Controller FSM of the frame decoder: handshakes and run sequencing.
// Depends on rcibus_pkg and the defines header.
`include "rc_ibus_frame_decoder_unit_defines.svh"

module rcibus_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_req,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  rcibus_pkg::dp_stat_t stat,
  output rcibus_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   in_acc;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_EMIT);
  assign in_acc     = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.start_st  = rcibus_pkg::ST_CHAN;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (rcibus_pkg::req_t'(in_req) == rcibus_pkg::REQ_TICK) begin
            cmd.tick = 1'b1;
            if (stat.fs_expire) begin
              cmd.start    = 1'b1;
              cmd.start_st = rcibus_pkg::ST_FAILSAFE;
              state_nxt    = S_EMIT;
            end
          end else begin
            cmd.byte_wr = 1'b1;
            if (stat.frame_end) begin
              cmd.start = 1'b1;
              if (!stat.hdr_ok) begin
                cmd.start_st = rcibus_pkg::ST_BAD_HDR;
                state_nxt    = S_EMIT;
              end else if (!stat.sum_ok) begin
                cmd.start_st = rcibus_pkg::ST_BAD_SUM;
                state_nxt    = S_EMIT;
              end else begin
                cmd.start_st = rcibus_pkg::ST_CHAN;
                state_nxt    = S_FETCH;
              end
            end
          end
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_tready) begin
          if (stat.last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.next_chan = 1'b1;
            state_nxt     = stat.chan_mode ? S_FETCH : S_EMIT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `RCIBUS_ASSERT_NXT(a_good_frame_fetch, clk, rst_n,
    cmd.byte_wr && stat.frame_end && stat.hdr_ok && stat.sum_ok, state_r == S_FETCH)
  `RCIBUS_ASSERT_NXT(a_fetch_then_emit, clk, rst_n, state_r == S_FETCH, out_tvalid)
  `RCIBUS_ASSERT_NXT(a_last_to_idle, clk, rst_n,
    out_tvalid && out_tready && stat.last, in_tready && !out_tvalid)

endmodule

// ===== rtl/rcibus_datapath.sv =====
// Datapath of the frame decoder: frame RAM, checksum, header flags,
// failsafe counter, limit register and the result fields. Depends on rcibus_pkg.
`include "rc_ibus_frame_decoder_unit_defines.svh"

module rcibus_datapath #(
  parameter int CHANNELS = rcibus_pkg::CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rcibus_pkg::dp_cmd_t                  cmd,
  output rcibus_pkg::dp_stat_t                 stat,
  input  logic [7:0]                           rx_byte,
  input  logic                                 cfg_we,
  input  logic [rcibus_pkg::LIMIT_W-1:0]       cfg_wdata,
  output logic [1:0]                           res_status,
  output logic [rcibus_pkg::IDX_W-1:0]         res_index,
  output logic [rcibus_pkg::VAL_W-1:0]         res_value
);

  localparam logic [rcibus_pkg::IDX_W-1:0] LAST_CHAN = rcibus_pkg::IDX_W'(CHANNELS - 1);

  logic [7:0]                      mem [rcibus_pkg::FRAME_LEN];
  logic [rcibus_pkg::POS_W-1:0]    pos_r;
  logic [rcibus_pkg::VAL_W-1:0]    sum_r;
  logic [7:0]                      csum_lo_r;
  logic                            hdr0_ok_r, hdr1_ok_r;
  logic [rcibus_pkg::LIMIT_W-1:0]  limit_r, fs_cnt_r, fs_cnt_inc;
  rcibus_pkg::status_t             status_r;
  logic [rcibus_pkg::IDX_W-1:0]    chan_r;
  logic [7:0]                      rd_lo_r, rd_hi_r;
  logic [rcibus_pkg::POS_W-1:0]    rd_addr_lo, rd_addr_hi;
  logic                            frame_end;
  logic                            bad_run;

  assign frame_end  = (pos_r == rcibus_pkg::CSUM_HI_POS);
  assign fs_cnt_inc = fs_cnt_r + 1'b1;
  // channel i sits at bytes 2+2i (low) and 3+2i (high)
  assign rd_addr_lo = {chan_r, 1'b0} + rcibus_pkg::POS_W'(2);
  assign rd_addr_hi = rd_addr_lo | rcibus_pkg::POS_W'(1);
  assign bad_run    = (status_r == rcibus_pkg::ST_BAD_HDR) ||
                      (status_r == rcibus_pkg::ST_BAD_SUM);

  assign stat.frame_end = frame_end;
  assign stat.hdr_ok    = hdr0_ok_r && hdr1_ok_r;
  // bytes 30,31 are not summed, so sum_r is final once byte 31 arrives
  assign stat.sum_ok    = ({rx_byte, csum_lo_r} == sum_r);
  assign stat.fs_expire = !(limit_r > fs_cnt_inc);
  assign stat.chan_mode = (status_r == rcibus_pkg::ST_CHAN);
  assign stat.last      = bad_run || (chan_r == LAST_CHAN);

  // frame RAM: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.byte_wr) begin
      mem[pos_r] <= rx_byte;
    end
    if (cmd.fetch) begin
      rd_lo_r <= mem[rd_addr_lo];
      rd_hi_r <= mem[rd_addr_hi];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_wr) begin
      if (pos_r == rcibus_pkg::HDR0_POS) hdr0_ok_r <= (rx_byte == rcibus_pkg::HDR0_BYTE);
      if (pos_r == rcibus_pkg::HDR1_POS) hdr1_ok_r <= (rx_byte == rcibus_pkg::HDR1_BYTE);
      if (pos_r == rcibus_pkg::CSUM_LO_POS) csum_lo_r <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_r    <= rcibus_pkg::SUM_INIT;
      fs_cnt_r <= '0;
      limit_r  <= rcibus_pkg::LIMIT_RESET;
      status_r <= rcibus_pkg::ST_CHAN;
      chan_r   <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (cmd.byte_wr) begin
        pos_r <= pos_r + 1'b1;
        if (frame_end) begin
          sum_r    <= rcibus_pkg::SUM_INIT;
          fs_cnt_r <= '0;
        end else if (pos_r <= rcibus_pkg::SUM_LAST_POS) begin
          sum_r <= sum_r - {8'h00, rx_byte};
        end
      end
      if (cmd.tick) begin
        fs_cnt_r <= stat.fs_expire ? '0 : fs_cnt_inc;
      end
      if (cmd.start) begin
        status_r <= cmd.start_st;
        chan_r   <= '0;
      end else if (cmd.next_chan) begin
        chan_r <= chan_r + 1'b1;
      end
    end
  end

  always_comb begin
    res_status = status_r;
    res_index  = bad_run ? '0 : chan_r;
    case (status_r)
      rcibus_pkg::ST_CHAN:     res_value = {rd_hi_r, rd_lo_r};
      rcibus_pkg::ST_FAILSAFE: res_value = (chan_r == rcibus_pkg::MID_CH_A ||
                                            chan_r == rcibus_pkg::MID_CH_B) ?
                                           rcibus_pkg::DEFAULT_MID : '0;
      default:                 res_value = '0;
    endcase
  end

  `RCIBUS_ASSERT_NXT(a_sum_reload, clk, rst_n,
    cmd.byte_wr && frame_end, sum_r == rcibus_pkg::SUM_INIT && fs_cnt_r == '0)
  `RCIBUS_ASSERT_NXT(a_fs_clear, clk, rst_n, cmd.tick && stat.fs_expire, fs_cnt_r == '0)
  `RCIBUS_ASSERT_IMP(a_bad_single, clk, rst_n, bad_run, stat.last && res_index == '0)

endmodule
